FILE: design/range_prime_counter_macros.svh
// assertion macros for the range prime counter
`ifndef RANGE_PRIME_COUNTER_MACROS_SVH
`define RANGE_PRIME_COUNTER_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define RPC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("range prime counter: same-cycle check failed");

// antecedent holds, consequent holds in the next cycle
`define RPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("range prime counter: next-cycle check failed");

`endif

FILE: design/rpc_pkg.sv
`timescale 1ns / 1ps

package rpc_pkg;

  // width of numbers, limit and chunk start
  localparam int VALUE_WIDTH = 31;
  // chunk length register and result count
  localparam int CHUNK_WIDTH = 17;
  localparam int COUNT_WIDTH = 16;
  localparam logic [CHUNK_WIDTH-1:0] CHUNK_RESET = CHUNK_WIDTH'(10000);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // configuration data port is as wide as the widest register
  localparam int CFG_WIDTH = (VALUE_WIDTH > CHUNK_WIDTH) ? VALUE_WIDTH : CHUNK_WIDTH;
  // candidate walks up to limit plus one step
  localparam int CAND_WIDTH = VALUE_WIDTH + 1;
  // chunk end and range compares
  localparam int END_WIDTH = CFG_WIDTH + 1;
  // trial divisor never passes about sqrt(2^VALUE_WIDTH) + 2
  localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int SQ_WIDTH = 2 * DIV_WIDTH;
  // bit counter of the serial divider
  localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH);

  localparam logic [DIV_WIDTH-1:0] FIRST_DIVISOR = DIV_WIDTH'(3);
  localparam logic [SQ_WIDTH-1:0] FIRST_SQUARE = SQ_WIDTH'(9);

  // configuration register indexes
  localparam logic REG_UPPER_LIMIT = 1'b0;
  localparam logic REG_CHUNK_LENGTH = 1'b1;

  // request into the serial divider
  typedef struct packed {
    logic start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [DIV_WIDTH-1:0] divisor;
  } div_req_t;

  // status back from the serial divider
  typedef struct packed {
    logic running;
    logic done;
    logic rem_zero;
  } div_rsp_t;

  // sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CAND  = 5'b00010,
    S_TRIAL = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

FILE: design/rpc_divider.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle, only the remainder is kept
module rpc_divider (
  input  logic              clk,
  input  logic              rst,
  input  rpc_pkg::div_req_t req,
  output rpc_pkg::div_rsp_t rsp
);

  logic [rpc_pkg::VALUE_WIDTH-1:0]   dividend;
  logic [rpc_pkg::DIV_WIDTH-1:0]     divisor;
  logic [rpc_pkg::DIV_WIDTH-1:0]     remainder_work;
  logic [rpc_pkg::DIV_WIDTH-1:0]     remainder_next;
  logic [rpc_pkg::BIT_CNT_WIDTH-1:0] bit_cnt;
  logic                              running;
  logic                              done;
  logic [rpc_pkg::DIV_WIDTH:0]       trial;
  logic [rpc_pkg::DIV_WIDTH:0]       divisor_ext;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {remainder_work, dividend[rpc_pkg::VALUE_WIDTH-1]};
    divisor_ext = {1'b0, divisor};
    if (trial >= divisor_ext) begin
      remainder_next = rpc_pkg::DIV_WIDTH'(trial - divisor_ext);
    end else begin
      remainder_next = trial[rpc_pkg::DIV_WIDTH-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
      end else if (running && bit_cnt == '0) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dividend <= req.dividend;
      divisor <= req.divisor;
      remainder_work <= '0;
      bit_cnt <= rpc_pkg::BIT_CNT_WIDTH'(rpc_pkg::VALUE_WIDTH - 1);
    end else if (running) begin
      dividend <= {dividend[rpc_pkg::VALUE_WIDTH-2:0], 1'b0};
      remainder_work <= remainder_next;
      bit_cnt <= bit_cnt - 1'b1;
    end
  end

  assign rsp.running = running;
  assign rsp.done = done;
  assign rsp.rem_zero = (remainder_work == '0);

endmodule

FILE: design/range_prime_counter.sv
`timescale 1ns / 1ps

// channel        signals                            direction
// -------------  ---------------------------------  ---------
// command        start, busy, chunk_start           in / out
// result         done, prime_count                  out
// configuration  wr_en, wr_index, wr_data           in
//
// a command is taken when start is high and busy is low; busy stays high
// until the result is shown. an even candidate or one is settled in S_CAND; an odd
// one passes S_CAND, then S_TRIAL and the bit-serial divider in S_DIV per trial
// divisor, and one more S_TRIAL if it is prime; the chunk ends in S_DONE.
// reset is synchronous: upper_limit clears, chunk_length returns to 10000.
// done is high for one cycle with prime_count; the receiver cannot stall it.

`include "range_prime_counter_macros.svh"

module range_prime_counter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rpc_pkg::VALUE_WIDTH-1:0] chunk_start,
  output logic                          done,
  output logic [rpc_pkg::COUNT_WIDTH-1:0] prime_count,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [rpc_pkg::CFG_WIDTH-1:0] wr_data
);

  rpc_pkg::state_t state;
  rpc_pkg::state_t state_next;

  logic [rpc_pkg::VALUE_WIDTH-1:0] upper_limit;
  logic [rpc_pkg::CHUNK_WIDTH-1:0] chunk_length;

  logic [rpc_pkg::CAND_WIDTH-1:0]  candidate;
  logic [rpc_pkg::END_WIDTH-1:0]   chunk_end;
  logic [rpc_pkg::DIV_WIDTH-1:0]   trial_divisor;
  logic [rpc_pkg::SQ_WIDTH-1:0]    divisor_sq;
  logic [rpc_pkg::COUNT_WIDTH-1:0] found_count;

  rpc_pkg::div_req_t div_req;
  rpc_pkg::div_rsp_t div_rsp;

  logic accept;
  logic in_range;
  logic below_two;
  logic is_even;
  logic sq_above;
  logic [rpc_pkg::END_WIDTH-1:0] cand_ext;

  assign accept = start && (state == rpc_pkg::S_IDLE);
  assign busy = (state != rpc_pkg::S_IDLE);
  assign done = (state == rpc_pkg::S_DONE);
  assign prime_count = found_count;

  // candidate tests
  always_comb begin
    cand_ext = rpc_pkg::END_WIDTH'(candidate);
    in_range = (cand_ext < chunk_end) &&
               (candidate < rpc_pkg::CAND_WIDTH'(upper_limit));
    below_two = (candidate < rpc_pkg::CAND_WIDTH'(2));
    is_even = ~candidate[0];
    sq_above = (divisor_sq > rpc_pkg::SQ_WIDTH'(candidate));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= '0;
      chunk_length <= rpc_pkg::CHUNK_RESET;
    end else if (wr_en) begin
      case (wr_index)
        rpc_pkg::REG_UPPER_LIMIT: upper_limit <= wr_data[rpc_pkg::VALUE_WIDTH-1:0];
        rpc_pkg::REG_CHUNK_LENGTH: chunk_length <= wr_data[rpc_pkg::CHUNK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      rpc_pkg::S_IDLE: begin
        if (start) state_next = rpc_pkg::S_CAND;
      end
      rpc_pkg::S_CAND: begin
        if (!in_range) state_next = rpc_pkg::S_DONE;
        else if (!below_two && !is_even) state_next = rpc_pkg::S_TRIAL;
      end
      rpc_pkg::S_TRIAL: begin
        if (sq_above) state_next = rpc_pkg::S_CAND;
        else state_next = rpc_pkg::S_DIV;
      end
      rpc_pkg::S_DIV: begin
        if (div_rsp.done) begin
          if (div_rsp.rem_zero) state_next = rpc_pkg::S_CAND;
          else state_next = rpc_pkg::S_TRIAL;
        end
      end
      rpc_pkg::S_DONE: state_next = rpc_pkg::S_IDLE;
      default: state_next = rpc_pkg::S_IDLE;
    endcase
  end

  // divider launch
  always_comb begin
    div_req.start = (state == rpc_pkg::S_TRIAL) && !sq_above;
    div_req.dividend = candidate[rpc_pkg::VALUE_WIDTH-1:0];
    div_req.divisor = trial_divisor;
  end

  // state and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rpc_pkg::S_IDLE;
      found_count <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        found_count <= '0;
      end else if (found_count != rpc_pkg::COUNT_MAX) begin
        // even candidate counts only when it is two; odd counts when no divisor hit
        if ((state == rpc_pkg::S_CAND && in_range && is_even &&
             candidate == rpc_pkg::CAND_WIDTH'(2)) ||
            (state == rpc_pkg::S_TRIAL && sq_above)) begin
          found_count <= found_count + 1'b1;
        end
      end
    end
  end

  // candidate walk and divisor stepping
  always_ff @(posedge clk) begin
    if (accept) begin
      candidate <= rpc_pkg::CAND_WIDTH'(chunk_start);
      chunk_end <= rpc_pkg::END_WIDTH'(chunk_start) + rpc_pkg::END_WIDTH'(chunk_length);
    end else begin
      case (state)
        rpc_pkg::S_CAND: begin
          if (in_range && (below_two || is_even)) begin
            candidate <= candidate + rpc_pkg::CAND_WIDTH'(2);
          end
          trial_divisor <= rpc_pkg::FIRST_DIVISOR;
          divisor_sq <= rpc_pkg::FIRST_SQUARE;
        end
        rpc_pkg::S_TRIAL: begin
          if (sq_above) candidate <= candidate + rpc_pkg::CAND_WIDTH'(2);
        end
        rpc_pkg::S_DIV: begin
          if (div_rsp.done) begin
            if (div_rsp.rem_zero) begin
              candidate <= candidate + rpc_pkg::CAND_WIDTH'(2);
            end else begin
              // (d + 2)^2 = d^2 + 4d + 4
              trial_divisor <= trial_divisor + rpc_pkg::DIV_WIDTH'(2);
              divisor_sq <= divisor_sq + rpc_pkg::SQ_WIDTH'({trial_divisor, 2'b00}) +
                            rpc_pkg::SQ_WIDTH'(4);
            end
          end
        end
        default: ;
      endcase
    end
  end

  rpc_divider u_divider (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // checks
  `RPC_ASSERT_NEXT(a_accept_walks, clk, rst, accept, state == rpc_pkg::S_CAND)
  `RPC_ASSERT_NEXT(a_done_returns, clk, rst, done, !busy)
  `RPC_ASSERT_NEXT(a_div_launched, clk, rst, div_req.start, div_rsp.running && state == rpc_pkg::S_DIV)
  `RPC_ASSERT_SAME(a_div_only_in_div, clk, rst, div_rsp.running, state == rpc_pkg::S_DIV)

endmodule
